### sv/irpsn_pkg.sv
// shared types and constants of the ir pulse segment normalizer
package irpsn_pkg;

    localparam int DUR_W  = 15;
    localparam int SEG_W  = 24;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_POLARITY = 1'b0;

    typedef struct packed {
        logic             first_level;
        logic [DUR_W-1:0] first_duration;
        logic             second_level;
        logic [DUR_W-1:0] second_duration;
        logic             frame_end;
    } sym_t;

    typedef struct packed {
        logic [SEG_W-1:0] seg_duration;
        logic             seg_on;
        logic             empty_frame;
        logic             last;
    } res_t;

endpackage

### sv/irpsn_if.sv
// item channels of the ir pulse segment normalizer
interface irpsn_in_if;
    import irpsn_pkg::*;

    logic             valid;
    logic             ready;
    logic             first_level;
    logic [DUR_W-1:0] first_duration;
    logic             second_level;
    logic [DUR_W-1:0] second_duration;
    logic             frame_end;

    modport source (
        output valid, first_level, first_duration, second_level, second_duration,
               frame_end,
        input  ready
    );
    modport sink (
        input  valid, first_level, first_duration, second_level, second_duration,
               frame_end,
        output ready
    );
endinterface

interface irpsn_out_if;
    import irpsn_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] seg_duration;
    logic             seg_on;
    logic             empty_frame;
    logic             last;

    modport source (
        output valid, seg_duration, seg_on, empty_frame, last,
        input  ready
    );
    modport sink (
        input  valid, seg_duration, seg_on, empty_frame, last,
        output ready
    );
endinterface

### sv/ir_pulse_segment_normalizer_top.sv
// top level of the ir pulse segment normalizer
// Turns captured ir symbols into alternating carrier segment durations. An accepted item
// is held in the input register until the result buffer can take it; its zero to three
// results are then loaded into a three-entry result buffer and shown one per cycle while
// the receiver is ready. The next item waits in the input register until the buffer is
// empty or its last entry leaves, so a new item can wait there while results drain. Frame
// state and the carrier polarity bit are kept in flip-flops; the polarity bit (1: line
// level 0 means carrier on) is register 0 at byte address 0 and resets to 1.
module ir_pulse_segment_normalizer_top #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    irpsn_in_if.sink                     in_ch,
    irpsn_out_if.source                  out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irpsn_pkg::ADDR_W-1:0] paddr,
    input  logic [irpsn_pkg::DATA_W-1:0] pwdata,
    output logic [irpsn_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import irpsn_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic                   carrier_pol_reg;
    logic                   in_valid_reg;
    sym_t                   item_reg;
    logic                   pv_reg;
    logic                   pon_reg;
    logic [LENGTH_BITS-1:0] plen_reg;
    logic                   pfirst_reg;
    logic                   emitted_reg;
    logic [1:0]             cnt_reg;
    res_t                   rbuf_reg [3];

    logic                   pv_next;
    logic                   pon_next;
    logic [LENGTH_BITS-1:0] plen_next;
    logic                   pfirst_next;
    logic                   emitted_next;
    logic [1:0]             cnt_next;
    res_t                   res_next [3];

    logic move;
    logic pop;
    logic cfg_wr;
    logic reg_sel;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_POLARITY);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_sel ? {{(DATA_W-1){1'b0}}, carrier_pol_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_pol_reg <= 1'b1;
        end
        else if (cfg_wr && reg_sel)
        begin
            carrier_pol_reg <= pwdata[0];
        end
    end

    // handshakes
    assign pop         = out_ch.valid && out_ch.ready;
    assign move        = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign in_ch.ready = !in_valid_reg || move;

    assign out_ch.valid        = (cnt_reg != 2'd0);
    assign out_ch.seg_duration = rbuf_reg[0].seg_duration;
    assign out_ch.seg_on       = rbuf_reg[0].seg_on;
    assign out_ch.empty_frame  = rbuf_reg[0].empty_frame;
    assign out_ch.last         = rbuf_reg[0].last;

    // segment merge for one symbol
    always_comb
    begin
        logic                   lvl;
        logic [DUR_W-1:0]       dur;
        logic                   on;
        logic [LENGTH_BITS:0]   sum;
        logic                   pv;
        logic                   pon;
        logic [LENGTH_BITS-1:0] plen;
        logic                   pfirst;
        logic                   emitted;
        logic [1:0]             n;

        pv      = pv_reg;
        pon     = pon_reg;
        plen    = plen_reg;
        pfirst  = pfirst_reg;
        emitted = emitted_reg;
        n       = 2'd0;
        sum     = '0;
        for (int i = 0; i < 3; i++)
        begin
            res_next[i] = '0;
        end

        for (int h = 0; h < 2; h++)
        begin
            lvl = (h == 0) ? item_reg.first_level : item_reg.second_level;
            dur = (h == 0) ? item_reg.first_duration : item_reg.second_duration;
            on  = ((lvl == 1'b0) == carrier_pol_reg);
            if (dur != '0)
            begin
                if (pv && (pon == on))
                begin
                    sum  = {1'b0, plen} + (LENGTH_BITS+1)'(dur);
                    plen = sum[LENGTH_BITS] ? LEN_MAX : sum[LENGTH_BITS-1:0];
                end
                else
                begin
                    if (pv)
                    begin
                        if (!(pfirst && !pon))
                        begin
                            res_next[n].seg_duration = SEG_W'(plen);
                            res_next[n].seg_on       = pon;
                            n                        = n + 2'd1;
                            emitted                  = 1'b1;
                        end
                        pfirst = 1'b0;
                    end
                    pv   = 1'b1;
                    pon  = on;
                    plen = LENGTH_BITS'(dur);
                end
            end
        end

        if (item_reg.frame_end)
        begin
            if (pv && !(pfirst && !pon))
            begin
                res_next[n].seg_duration = SEG_W'(plen);
                res_next[n].seg_on       = pon;
                res_next[n].last         = 1'b1;
                n                        = n + 2'd1;
                emitted                  = 1'b1;
            end
            if (!emitted)
            begin
                res_next[n].empty_frame = 1'b1;
                res_next[n].last        = 1'b1;
                n                       = n + 2'd1;
            end
            pv      = 1'b0;
            pon     = 1'b0;
            plen    = '0;
            pfirst  = 1'b1;
            emitted = 1'b0;
        end

        pv_next      = pv;
        pon_next     = pon;
        plen_next    = plen;
        pfirst_next  = pfirst;
        emitted_next = emitted;
        cnt_next     = n;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pv_reg       <= 1'b0;
            pon_reg      <= 1'b0;
            plen_reg     <= '0;
            pfirst_reg   <= 1'b1;
            emitted_reg  <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end

            if (move)
            begin
                pv_reg      <= pv_next;
                pon_reg     <= pon_next;
                plen_reg    <= plen_next;
                pfirst_reg  <= pfirst_next;
                emitted_reg <= emitted_next;
                cnt_reg     <= cnt_next;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.first_level     <= in_ch.first_level;
            item_reg.first_duration  <= in_ch.first_duration;
            item_reg.second_level    <= in_ch.second_level;
            item_reg.second_duration <= in_ch.second_duration;
            item_reg.frame_end       <= in_ch.frame_end;
        end

        if (move)
        begin
            rbuf_reg[0] <= res_next[0];
            rbuf_reg[1] <= res_next[1];
            rbuf_reg[2] <= res_next[2];
        end
        else if (pop)
        begin
            rbuf_reg[0] <= rbuf_reg[1];
            rbuf_reg[1] <= rbuf_reg[2];
        end
    end

    a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.empty_frame |-> out_ch.last && (cnt_reg == 2'd1))
        else $error("empty frame marker not alone or not last");

    a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !rbuf_reg[0].last)
        else $error("last item shown before end of buffer");

    a_first_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !pfirst_reg |-> pv_reg)
        else $error("first segment closed with no pending segment");

    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg |-> !pfirst_reg)
        else $error("segment emitted while still first");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |=> in_valid_reg && $stable(item_reg))
        else $error("stalled item lost");

endmodule

### tb/sv/tb_ir_pulse_segment_normalizer_top.sv
// testbench of the ir pulse segment normalizer: directed and random symbol frames checked against a local predictor
`timescale 1ns / 100ps

module tb_ir_pulse_segment_normalizer_top;
    import irpsn_pkg::*;

    localparam int                LEN_BITS = 24;
    localparam logic [LEN_BITS:0] LEN_MAX  = {1'b0, {LEN_BITS{1'b1}}};
    localparam logic [ADDR_W-1:0] ADDR_POLARITY = {REG_POLARITY, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    irpsn_in_if  sym_ch ();
    irpsn_out_if seg_ch ();

    ir_pulse_segment_normalizer_top #(
        .LENGTH_BITS (LEN_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (sym_ch),
        .out_ch  (seg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic                carrier_low;
    logic                pend_valid;
    logic                pend_on;
    logic                pend_first;
    logic                any_emitted;
    logic [LEN_BITS-1:0] pend_len;
    res_t                seg_expect[$];

    sym_t sym_queue[$];
    sym_t cur_sym;
    int   syms_queued;
    int   syms_sent;
    int   idle_pct;
    int   stall_pct;
    int   fault_count;

    bit hold_req;
    bit hold_seen;
    int hold_left;

    always #6 clk = ~clk;

    function void log_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", what);
    endfunction

    function void close_segment(logic fin);
        res_t r;
        if (!pend_valid)
            return;
        if (!(pend_first && !pend_on))
        begin
            r.seg_duration = pend_len[SEG_W-1:0];
            r.seg_on       = pend_on;
            r.empty_frame  = 1'b0;
            r.last         = fin;
            seg_expect     = {seg_expect, r};
            any_emitted    = 1'b1;
        end
        pend_first = 1'b0;
        pend_valid = 1'b0;
    endfunction

    function void merge_half(logic level, logic [DUR_W-1:0] dur);
        logic              on;
        logic [LEN_BITS:0] sum;
        if (dur == '0)
            return;
        on = ((level == 1'b0) == carrier_low);
        if (pend_valid && pend_on == on)
        begin
            sum = {1'b0, pend_len} + (LEN_BITS+1)'(dur);
            pend_len = (sum > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : sum[LEN_BITS-1:0];
            return;
        end
        close_segment(1'b0);
        pend_valid = 1'b1;
        pend_on    = on;
        pend_len   = LEN_BITS'(dur);
    endfunction

    function void segment_symbol(sym_t s);
        res_t r;
        merge_half(s.first_level, s.first_duration);
        merge_half(s.second_level, s.second_duration);
        if (s.frame_end)
        begin
            close_segment(1'b1);
            if (!any_emitted)
            begin
                r.seg_duration = '0;
                r.seg_on       = 1'b0;
                r.empty_frame  = 1'b1;
                r.last         = 1'b1;
                seg_expect     = {seg_expect, r};
            end
            pend_valid  = 1'b0;
            pend_on     = 1'b0;
            pend_len    = '0;
            pend_first  = 1'b1;
            any_emitted = 1'b0;
        end
    endfunction

    function void queue_symbol(logic fl, logic [DUR_W-1:0] fd, logic sl,
                               logic [DUR_W-1:0] sd, logic fe);
        sym_t s;
        s.first_level     = fl;
        s.first_duration  = fd;
        s.second_level    = sl;
        s.second_duration = sd;
        s.frame_end       = fe;
        sym_queue         = {sym_queue, s};
        syms_queued++;
    endfunction

    function logic [DUR_W-1:0] rand_duration();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return DUR_W'($urandom_range(32767));
            default: return DUR_W'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic queue_random_frames(int n);
        int   made;
        int   len;
        logic lvl;
        logic fl;
        logic sl;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                queue_symbol(1'($urandom_range(1)), DUR_W'($urandom_range(32767)),
                             1'($urandom_range(1)), DUR_W'($urandom_range(32767)),
                             1'($urandom_range(1)));
                made++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                lvl = 1'($urandom_range(1));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(3) != 0)
                    begin
                        fl = lvl;
                        sl = ~lvl;
                    end
                    else
                    begin
                        fl = 1'($urandom_range(1));
                        sl = 1'($urandom_range(1));
                    end
                    queue_symbol(fl, rand_duration(), sl, rand_duration(), i == len - 1);
                    made++;
                end
            end
        end
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_POLARITY)
            carrier_low = data[0];
    endtask

    task automatic apb_check_polarity();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POLARITY;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {{(DATA_W-1){1'b0}}, carrier_low})
            log_fault($sformatf("polarity readback: expected %0d got %h",
                                carrier_low, prdata));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_polarity(logic [ADDR_W-1:0] addr, logic value);
        apb_write(addr, {{(DATA_W-1){1'b0}}, value});
        apb_check_polarity();
    endtask

    task automatic drain_phase();
        while (syms_sent != syms_queued || seg_expect.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sym_ch.valid <= 1'b0;
        end
        else
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                segment_symbol(cur_sym);
                syms_sent++;
            end
            if (!sym_ch.valid || sym_ch.ready)
            begin
                if (sym_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_sym = sym_queue.pop_front();
                    sym_ch.valid           <= 1'b1;
                    sym_ch.first_level     <= cur_sym.first_level;
                    sym_ch.first_duration  <= cur_sym.first_duration;
                    sym_ch.second_level    <= cur_sym.second_level;
                    sym_ch.second_duration <= cur_sym.second_duration;
                    sym_ch.frame_end       <= cur_sym.frame_end;
                end
                else
                begin
                    sym_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : seg_monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            seg_ch.ready <= 1'b0;
        end
        else
        begin
            if (seg_ch.valid && seg_ch.ready)
            begin
                got.seg_duration = seg_ch.seg_duration;
                got.seg_on       = seg_ch.seg_on;
                got.empty_frame  = seg_ch.empty_frame;
                got.last         = seg_ch.last;
                if (seg_expect.size() == 0)
                begin
                    log_fault($sformatf("unexpected item: dur %0d on %b empty %b last %b",
                                        got.seg_duration, got.seg_on, got.empty_frame,
                                        got.last));
                end
                else
                begin
                    want = seg_expect.pop_front();
                    if (got !== want)
                        log_fault($sformatf({"item mismatch: expected dur %0d on %b ",
                                             "empty %b last %b, got dur %0d on %b ",
                                             "empty %b last %b"},
                                            want.seg_duration, want.seg_on,
                                            want.empty_frame, want.last,
                                            got.seg_duration, got.seg_on,
                                            got.empty_frame, got.last));
                end
            end
            seg_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_ir_pulse_segment_normalizer_top: errors");
        $finish;
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sym_ch.valid           = 1'b0;
        sym_ch.first_level     = 1'b0;
        sym_ch.first_duration  = '0;
        sym_ch.second_level    = 1'b0;
        sym_ch.second_duration = '0;
        sym_ch.frame_end       = 1'b0;
        seg_ch.ready           = 1'b0;
        carrier_low            = 1'b1;
        pend_valid             = 1'b0;
        pend_on                = 1'b0;
        pend_first             = 1'b1;
        any_emitted            = 1'b0;
        pend_len               = '0;
        syms_queued            = 0;
        syms_sent              = 0;
        idle_pct               = 0;
        stall_pct              = 0;
        fault_count            = 0;
        hold_req               = 1'b0;
        hold_seen              = 1'b0;
        hold_left              = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, level 0 is carrier on
        set_polarity(ADDR_POLARITY, 1'b1);
        queue_symbol(1'b0, 15'd0, 1'b1, 15'd0, 1'b1);
        queue_symbol(1'b1, 15'd100, 1'b1, 15'd200, 1'b1);
        queue_symbol(1'b0, '1, 1'b1, '1, 1'b0);
        queue_symbol(1'b1, 15'd0, 1'b0, 15'd5, 1'b0);
        queue_symbol(1'b0, 15'd1, 1'b1, 15'd0, 1'b1);
        queue_symbol(1'b1, 15'd50, 1'b0, 15'd70, 1'b0);
        queue_symbol(1'b1, 15'd30, 1'b0, 15'd40, 1'b1);
        queue_symbol(1'b0, '1, 1'b0, '1, 1'b0);
        queue_symbol(1'b0, '1, 1'b1, 15'd1, 1'b1);
        queue_symbol(1'b1, 15'd0, 1'b1, 15'd0, 1'b0);
        queue_symbol(1'b0, 15'd10, 1'b1, 15'd0, 1'b0);
        queue_symbol(1'b0, 15'd0, 1'b0, 15'd0, 1'b1);
        queue_symbol(1'b1, 15'd7, 1'b0, 15'd9, 1'b1);
        queue_symbol(1'b0, 15'd0, 1'b0, 15'd0, 1'b0);
        queue_symbol(1'b1, 15'd0, 1'b1, 15'd0, 1'b1);
        queue_symbol(1'b0, 15'h5555, 1'b1, 15'h2aaa, 1'b0);
        queue_symbol(1'b0, 15'h2aaa, 1'b1, 15'h5555, 1'b1);
        drain_phase();

        set_polarity(ADDR_POLARITY, 1'b0);
        idle_pct = 57;
        queue_random_frames(50);
        drain_phase();

        set_polarity(ADDR_POLARITY, 1'b1);
        idle_pct  = 0;
        stall_pct = 57;
        queue_random_frames(50);
        drain_phase();

        // unmapped register index leaves polarity alone
        set_polarity(ADDR_UNMAPPED, 1'b0);
        idle_pct  = 37;
        stall_pct = 37;
        queue_random_frames(50);
        drain_phase();

        // receiver held off while items keep coming
        set_polarity(ADDR_POLARITY, 1'b0);
        idle_pct  = 0;
        stall_pct = 20;
        hold_req  = ~hold_req;
        queue_random_frames(50);
        drain_phase();

        // saturating merge of one long carrier-on segment
        set_polarity(ADDR_POLARITY, 1'b1);
        stall_pct = 0;
        for (int i = 0; i < 257; i++)
            queue_symbol(1'b0, '1, 1'b0, '1, 1'b0);
        queue_symbol(1'b1, '1, 1'b0, 15'd0, 1'b1);
        queue_random_frames(8);
        drain_phase();

        if (fault_count == 0)
            $display("tb_ir_pulse_segment_normalizer_top: clean");
        else
            $display("tb_ir_pulse_segment_normalizer_top: errors");
        $finish;
    end

endmodule

### sim.f
sv/irpsn_pkg.sv
sv/irpsn_if.sv
sv/ir_pulse_segment_normalizer_top.sv
tb/sv/tb_ir_pulse_segment_normalizer_top.sv
